// File: sv/kcl_pkg.sv
// Shared types and constants for the keypad code lock.
// Holds the item structs, mode and event codes, and register indexes.
// No dependencies.
package kcl_pkg;

   localparam int CODE_LEN = 4;
   localparam int KEY_W    = 8;
   localparam int CNT_W    = 3;
   localparam int ATT_W    = 4;
   localparam int TICK_W   = 16;
   localparam int IDX_W    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BLOCK_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WARN_TICKS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOCK_KEY     = 2'd3;

   localparam logic [ATT_W-1:0]  MAX_ATTEMPTS_RST = 4'd5;
   localparam logic [TICK_W-1:0] BLOCK_TICKS_RST  = 16'd6;
   localparam logic [TICK_W-1:0] WARN_TICKS_RST   = 16'd2;
   localparam logic [KEY_W-1:0]  LOCK_KEY_RST     = 8'd42;

   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [1:0] {
      MODE_SET   = 2'd0,
      MODE_LOGIN = 2'd1,
      MODE_OPEN  = 2'd2,
      MODE_HOLD  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_STORED   = 3'd1,
      EV_ACCEPTED = 3'd2,
      EV_REJECTED = 3'd3,
      EV_LOCKOUT  = 3'd4,
      EV_RELOCKED = 3'd5,
      EV_HOLD_END = 3'd6
   } evt_type;

   typedef struct packed {
      logic             command;
      logic [KEY_W-1:0] key_code;
   } req_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic              door_open;
      logic [CNT_W-1:0]  digits_entered;
      logic [ATT_W-1:0]  attempts_left;
      logic [TICK_W-1:0] hold_left;
      logic [2:0]        event_res;
   } rsp_type;

   typedef struct packed {
      logic [ATT_W-1:0]  max_attempts;
      logic [TICK_W-1:0] block_ticks;
      logic [TICK_W-1:0] warn_ticks;
      logic [KEY_W-1:0]  lock_key;
   } cfg_type;

   // Control state of the lock
   typedef struct packed {
      mode_type          mode;
      logic [CNT_W-1:0]  digit_count;
      logic [ATT_W-1:0]  attempt_count;
      logic [TICK_W-1:0] hold_count;
      logic              hold_is_lockout;
      logic              door_state;
   } ctl_type;

   // Code store write requests
   typedef struct packed {
      logic             store_we;
      logic             entry_we;
      logic [IDX_W-1:0] idx;
   } wr_type;

   typedef logic [CODE_LEN-1:0][KEY_W-1:0] code_type;

endpackage

// File: sv/kcl_step.sv
// Next-state and result logic of the keypad code lock for one item.
// Purely combinational; uses kcl_pkg types.
module kcl_step (
   input  kcl_pkg::ctl_type  ctl_cur,
   input  kcl_pkg::code_type stored_code,
   input  kcl_pkg::code_type entered_code,
   input  kcl_pkg::cfg_type  cfg,
   input  kcl_pkg::req_type  item,
   output kcl_pkg::ctl_type  ctl_nxt,
   output kcl_pkg::wr_type   wr,
   output kcl_pkg::rsp_type  rsp
);

   logic              is_key;
   logic              is_tick;
   logic              last_digit;
   logic              code_match;
   logic              relock;
   logic              hold_done;
   logic              att_low;
   kcl_pkg::mode_type mode_nxt;
   kcl_pkg::evt_type  evt;
   logic [kcl_pkg::KEY_W-1:0] probe;

   assign is_key     = (item.command == kcl_pkg::CMD_KEY);
   assign is_tick    = (item.command == kcl_pkg::CMD_TICK);
   assign last_digit = (ctl_cur.digit_count == kcl_pkg::CNT_W'(kcl_pkg::CODE_LEN - 1));
   assign relock     = (item.key_code == cfg.lock_key);
   assign hold_done  = (ctl_cur.hold_count <= kcl_pkg::TICK_W'(1));
   assign att_low    = (ctl_cur.attempt_count <= kcl_pkg::ATT_W'(1));

   // Final key completes the entry, so it is compared straight from the item
   always_comb begin
      code_match = 1'b1;
      probe      = '0;
      for (int i = 0; i < kcl_pkg::CODE_LEN; i++) begin
         probe = (i == kcl_pkg::CODE_LEN - 1) ? item.key_code : entered_code[i];
         if (probe != stored_code[i]) begin
            code_match = 1'b0;
         end
      end
   end

   // Next mode
   always_comb begin
      mode_nxt = ctl_cur.mode;
      case (ctl_cur.mode)
         kcl_pkg::MODE_SET: begin
            if (is_key && last_digit) begin
               mode_nxt = kcl_pkg::MODE_LOGIN;
            end
         end
         kcl_pkg::MODE_LOGIN: begin
            if (is_key && last_digit) begin
               mode_nxt = code_match ? kcl_pkg::MODE_OPEN : kcl_pkg::MODE_HOLD;
            end
         end
         kcl_pkg::MODE_OPEN: begin
            if (is_key && relock) begin
               mode_nxt = kcl_pkg::MODE_LOGIN;
            end
         end
         kcl_pkg::MODE_HOLD: begin
            if (is_tick && hold_done) begin
               mode_nxt = kcl_pkg::MODE_LOGIN;
            end
         end
         default: mode_nxt = ctl_cur.mode;
      endcase
   end

   // Counters, door, store writes and event
   always_comb begin
      ctl_nxt  = ctl_cur;
      evt      = kcl_pkg::EV_NONE;
      wr.store_we = 1'b0;
      wr.entry_we = 1'b0;
      wr.idx      = ctl_cur.digit_count[kcl_pkg::IDX_W-1:0];
      case (ctl_cur.mode)
         kcl_pkg::MODE_SET: begin
            if (is_key) begin
               wr.store_we = 1'b1;
               if (last_digit) begin
                  ctl_nxt.digit_count = '0;
                  evt = kcl_pkg::EV_STORED;
               end else begin
                  ctl_nxt.digit_count = ctl_cur.digit_count + kcl_pkg::CNT_W'(1);
               end
            end
         end
         kcl_pkg::MODE_LOGIN: begin
            if (is_key) begin
               wr.entry_we = 1'b1;
               if (last_digit) begin
                  ctl_nxt.digit_count = '0;
                  if (code_match) begin
                     ctl_nxt.door_state = 1'b1;
                     evt = kcl_pkg::EV_ACCEPTED;
                  end else if (att_low) begin
                     ctl_nxt.attempt_count   = '0;
                     ctl_nxt.hold_count      = cfg.block_ticks;
                     ctl_nxt.hold_is_lockout = 1'b1;
                     evt = kcl_pkg::EV_LOCKOUT;
                  end else begin
                     ctl_nxt.attempt_count   = ctl_cur.attempt_count - kcl_pkg::ATT_W'(1);
                     ctl_nxt.hold_count      = cfg.warn_ticks;
                     ctl_nxt.hold_is_lockout = 1'b0;
                     evt = kcl_pkg::EV_REJECTED;
                  end
               end else begin
                  ctl_nxt.digit_count = ctl_cur.digit_count + kcl_pkg::CNT_W'(1);
               end
            end
         end
         kcl_pkg::MODE_OPEN: begin
            if (is_key && relock) begin
               ctl_nxt.door_state  = 1'b0;
               ctl_nxt.digit_count = '0;
               evt = kcl_pkg::EV_RELOCKED;
            end
         end
         kcl_pkg::MODE_HOLD: begin
            if (is_tick) begin
               if (hold_done) begin
                  ctl_nxt.hold_count = '0;
                  if (ctl_cur.hold_is_lockout) begin
                     ctl_nxt.attempt_count = cfg.max_attempts;
                  end
                  ctl_nxt.hold_is_lockout = 1'b0;
                  ctl_nxt.digit_count     = '0;
                  evt = kcl_pkg::EV_HOLD_END;
               end else begin
                  ctl_nxt.hold_count = ctl_cur.hold_count - kcl_pkg::TICK_W'(1);
               end
            end
         end
         default: evt = kcl_pkg::EV_NONE;
      endcase
      ctl_nxt.mode = mode_nxt;
   end

   assign rsp.mode           = mode_nxt;
   assign rsp.door_open      = ctl_nxt.door_state;
   assign rsp.digits_entered = ctl_nxt.digit_count;
   assign rsp.attempts_left  = ctl_nxt.attempt_count;
   assign rsp.hold_left      = (mode_nxt == kcl_pkg::MODE_HOLD) ? ctl_nxt.hold_count : '0;
   assign rsp.event_res      = evt;

endmodule

// File: sv/keypad_code_lock_with_lockout_core.sv
// Keypad code lock with wrong-entry hold and lockout, top level.
// rsp_valid rises once an accepted req has passed the input register, then the
// result register. Throughput: one item per cycle while rsp_ready is high;
// the result register is refilled as it drains, and a stall holds the input.
// Reset: synchronous, active high; mode to code setting, door closed, attempts 5,
// registers to 5/6/2/42. Stored and entered codes are written before being read.
module keypad_code_lock_with_lockout_core (
   input  logic                              clock,
   input  logic                              reset,
   // item input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  kcl_pkg::req_type                  req_item,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output kcl_pkg::rsp_type                  rsp_item,
   // register writes
   input  logic                              csr_we,
   input  logic [kcl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kcl_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Input stage
   logic             in_valid_ff;
   kcl_pkg::req_type in_item_ff;
   // Result stage
   logic             out_valid_ff;
   kcl_pkg::rsp_type out_item_ff;
   // Lock state
   kcl_pkg::ctl_type  ctl_ff;
   kcl_pkg::code_type stored_ff;
   kcl_pkg::code_type entered_ff;
   kcl_pkg::cfg_type  cfg_ff;

   kcl_pkg::ctl_type ctl_in;
   kcl_pkg::wr_type  wr;
   kcl_pkg::rsp_type rsp_in;
   logic             advance;

   // The item in the input register is processed as soon as the result
   // register is empty or draining this cycle; state updates only then.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   kcl_step u_step (
      .ctl_cur      (ctl_ff),
      .stored_code  (stored_ff),
      .entered_code (entered_ff),
      .cfg          (cfg_ff),
      .item         (in_item_ff),
      .ctl_nxt      (ctl_in),
      .wr           (wr),
      .rsp          (rsp_in)
   );

   // Handshake control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         out_item_ff <= rsp_in;
      end
   end

   // Lock control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.mode            <= kcl_pkg::MODE_SET;
         ctl_ff.digit_count     <= '0;
         ctl_ff.attempt_count   <= kcl_pkg::MAX_ATTEMPTS_RST;
         ctl_ff.hold_count      <= '0;
         ctl_ff.hold_is_lockout <= 1'b0;
         ctl_ff.door_state      <= 1'b0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
      end
   end

   // Code stores: at most one key written per item, at the current digit position
   always_ff @(posedge clock) begin
      if (advance && wr.store_we) begin
         stored_ff[wr.idx] <= in_item_ff.key_code;
      end
      if (advance && wr.entry_we) begin
         entered_ff[wr.idx] <= in_item_ff.key_code;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_attempts <= kcl_pkg::MAX_ATTEMPTS_RST;
         cfg_ff.block_ticks  <= kcl_pkg::BLOCK_TICKS_RST;
         cfg_ff.warn_ticks   <= kcl_pkg::WARN_TICKS_RST;
         cfg_ff.lock_key     <= kcl_pkg::LOCK_KEY_RST;
      end else if (csr_we) begin
         case (csr_index)
            kcl_pkg::REG_MAX_ATTEMPTS: cfg_ff.max_attempts <= csr_wdata[kcl_pkg::ATT_W-1:0];
            kcl_pkg::REG_BLOCK_TICKS:  cfg_ff.block_ticks  <= csr_wdata[kcl_pkg::TICK_W-1:0];
            kcl_pkg::REG_WARN_TICKS:   cfg_ff.warn_ticks   <= csr_wdata[kcl_pkg::TICK_W-1:0];
            kcl_pkg::REG_LOCK_KEY:     cfg_ff.lock_key     <= csr_wdata[kcl_pkg::KEY_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

// File: sv/kcl_checker.sv
// Port-level checks for the keypad code lock top level.
// Uses kcl_pkg; attached to keypad_code_lock_with_lockout_core by bind.
module kcl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input kcl_pkg::rsp_type               rsp_item
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("result dropped or changed while stalled");

   // Door drive matches the open mode
   a_door_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.door_open == (rsp_item.mode == kcl_pkg::MODE_OPEN)))
      else $error("door drive disagrees with mode");

   // Hold ticks only show while holding
   a_hold_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.hold_left != '0) |-> (rsp_item.mode == kcl_pkg::MODE_HOLD))
      else $error("hold ticks outside hold");

   // An accepted entry opens the door
   a_accept_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.event_res == kcl_pkg::EV_ACCEPTED) |-> rsp_item.door_open)
      else $error("accepted entry without open door");

   // Partial entry never reaches the code length
   a_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.digits_entered < kcl_pkg::CNT_W'(kcl_pkg::CODE_LEN)))
      else $error("digit count out of range");

endmodule

bind keypad_code_lock_with_lockout_core kcl_checker u_kcl_checker (.*);
